// ----- rtl/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants of the fan duty controller: sequencer states,
// register indexes, duty widths and scaling constants.
// ----------------------------------------------------------------------------
package fdc_pkg;

   localparam int DUTY_W    = 7;
   localparam int CODE_W    = 8;
   localparam int DBAND_W   = 6;
   localparam int CSR_IDX_W = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_TEMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DUTY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP = 3'd4;

   // register reset values
   localparam int RST_MIN_TEMP  = 40;
   localparam int RST_FULL_TEMP = 80;
   localparam logic [DBAND_W-1:0] RST_DEADBAND  = 6'd2;
   localparam logic [DUTY_W-1:0]  RST_MIN_DUTY  = 7'd20;
   localparam logic [DUTY_W-1:0]  RST_SLEW_STEP = 7'd2;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
   localparam int CURVE_TOP = 100;

   // serial multiply over the min_duty bits, serial divide over the quotient bits
   localparam int MUL_STEPS = DUTY_W;
   localparam int QUO_W     = 8;

   // percent to 0..255 code: floor((p*255 + 50) / 100) by reciprocal
   localparam int CODE_BIAS   = 50;
   localparam int RECIP_100   = 41944;
   localparam int RECIP_SHIFT = 22;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_MUL,
      S_PREP,
      S_DIV,
      S_SLEW,
      S_CODE
   } state_type;

endpackage

// ----- rtl/fdc_req_if.sv -----
// ----------------------------------------------------------------------------
// fdc_req_if
// Request channel of the fan duty controller: one beat per control tick,
// carrying the CPU and GPU temperatures.
// ----------------------------------------------------------------------------
interface fdc_req_if #(
   parameter int TEMP_WIDTH = 8
);
   logic                  valid;
   logic                  ready;
   logic [TEMP_WIDTH-1:0] cpu_temp;
   logic [TEMP_WIDTH-1:0] gfx_temp;

   modport source (output valid, output cpu_temp, output gfx_temp, input ready);
   modport sink   (input valid, input cpu_temp, input gfx_temp, output ready);
endinterface

// ----- rtl/fdc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fdc_rsp_if
// Response channel of the fan duty controller: one beat per tick with the
// new duty, its 0..255 code and the change flag.
// ----------------------------------------------------------------------------
interface fdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fdc_pkg::DUTY_W-1:0]   duty_percent;
   logic [fdc_pkg::CODE_W-1:0]   duty_code;
   logic                         changed;

   modport source (output valid, output duty_percent, output duty_code, output changed,
                   input ready);
   modport sink   (input valid, input duty_percent, input duty_code, input changed,
                   output ready);
endinterface

// ----- rtl/fan_duty_controller_unit.sv -----
// sequence: eval, then on the curve path serial multiply, prep and serial divide,
// then slew and code; other paths go from eval straight to slew
// a new tick is taken only in idle, after the code step, which waits for a free
// response register; the serial multiply and restoring divide share one sequencer
// reset: synchronous active high; registers to defaults, kept duty to 0,
// no response pending
// ----------------------------------------------------------------------------
// fan_duty_controller_unit
// Fan duty from the hotter of two temperatures: hysteresis around the curve start,
// linear curve, half-up rounding, slew limit toward target; full temp jumps to full.
// ----------------------------------------------------------------------------
module fan_duty_controller_unit #(
   parameter int TEMP_WIDTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   fdc_req_if.sink                          req_ch,
   fdc_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [fdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [TEMP_WIDTH-1:0]            csr_wdata
);
   import fdc_pkg::*;

   localparam int PROD_W = DUTY_W + TEMP_WIDTH;
   localparam int DIVD_W = TEMP_WIDTH + 9;
   localparam int REM_W  = TEMP_WIDTH + 2;
   localparam int CNT_W  = $clog2(QUO_W);

   state_type state_ff, state_in;

   logic [TEMP_WIDTH-1:0] min_temp_ff, full_temp_ff;
   logic [DBAND_W-1:0]    deadband_ff;
   logic [DUTY_W-1:0]     min_duty_ff, slew_step_ff;

   logic [DUTY_W-1:0]     last_duty_ff, last_duty_in;
   logic [TEMP_WIDTH-1:0] temp_ff, temp_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DUTY_W-1:0]     mul_sh_ff, mul_sh_in;
   logic [PROD_W-1:0]     mcand_ff, mcand_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [QUO_W-1:0]      dq_ff, dq_in;
   logic [DUTY_W-1:0]     target_ff, target_in;
   logic                  full_ff, full_in;
   logic [DUTY_W-1:0]     next_ff, next_in;
   logic                  changed_ff, changed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]     rsp_duty_ff, rsp_duty_in;
   logic [CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic                  rsp_changed_ff, rsp_changed_in;

   // evaluation terms
   logic [TEMP_WIDTH-1:0] hot_temp;
   logic [TEMP_WIDTH:0]   temp_ext, lo_ext, on_edge;
   logic                  go_full, off_band, at_low, mul_done, div_done, rsp_free;
   logic [TEMP_WIDTH-1:0] span, rise;
   logic [DIVD_W-1:0]     numer, dividend;
   logic [REM_W:0]        trial, div2;
   logic                  fits;
   logic [QUO_W-1:0]      quo;
   logic [DUTY_W:0]       tgt_ext, last_ext, diff, move, sum;
   logic [DUTY_W:0]       step_ext;
   logic [DUTY_W-1:0]     slew_next;
   logic [14:0]           scaled;
   logic [31:0]           code_prod;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.duty_percent = rsp_duty_ff;
   assign rsp_ch.duty_code    = rsp_code_ff;
   assign rsp_ch.changed      = rsp_changed_ff;

   assign hot_temp = (req_ch.cpu_temp > req_ch.gfx_temp) ? req_ch.cpu_temp : req_ch.gfx_temp;
   assign temp_ext = {1'b0, temp_ff};
   assign lo_ext   = {1'b0, min_temp_ff};
   assign on_edge  = lo_ext + (TEMP_WIDTH+1)'(deadband_ff);
   assign go_full  = (temp_ff >= full_temp_ff);
   // off edge min_temp - deadband compared without going signed
   assign off_band = (last_duty_ff == '0) ? (temp_ext <= on_edge)
                   : ((temp_ext + (TEMP_WIDTH+1)'(deadband_ff)) < lo_ext);
   assign at_low   = (temp_ff <= min_temp_ff);
   assign mul_done = (cnt_ff == CNT_W'(MUL_STEPS - 1));
   assign div_done = (cnt_ff == CNT_W'(QUO_W - 1));
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // curve: N = min_duty*(max-t) + 100*(t-min), target = floor((2N+D)/(2D))
   assign span     = full_temp_ff - min_temp_ff;
   assign rise     = temp_ff - min_temp_ff;
   assign numer    = DIVD_W'(acc_ff) + DIVD_W'(rise) * DIVD_W'(CURVE_TOP);
   assign dividend = {numer[DIVD_W-2:0], 1'b0} + DIVD_W'(span);
   assign div2     = (REM_W+1)'({span, 1'b0});
   assign trial    = {rem_ff, dq_ff[QUO_W-1]};
   assign fits     = (trial >= div2);
   assign quo      = {dq_ff[QUO_W-2:0], fits};

   // slew limit toward target, or full duty at once when at full temperature
   assign tgt_ext  = {1'b0, target_ff};
   assign last_ext = {1'b0, last_duty_ff};
   assign step_ext = {1'b0, slew_step_ff};
   always_comb begin
      diff      = '0;
      move      = '0;
      sum       = '0;
      slew_next = last_duty_ff;
      if (full_ff) begin
         slew_next = DUTY_FULL;
      end else if (tgt_ext > last_ext) begin
         diff      = tgt_ext - last_ext;
         move      = (diff < step_ext) ? diff : step_ext;
         sum       = last_ext + move;
         slew_next = (sum > {1'b0, DUTY_FULL}) ? DUTY_FULL : sum[DUTY_W-1:0];
      end else if (tgt_ext < last_ext) begin
         diff      = last_ext - tgt_ext;
         move      = (diff < step_ext) ? diff : step_ext;
         sum       = last_ext - move;
         slew_next = sum[DUTY_W-1:0];
      end
   end

   assign scaled    = (15'(next_ff) << 8) - 15'(next_ff) + 15'(CODE_BIAS);
   assign code_prod = 32'(scaled) * 32'(RECIP_100);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (go_full || off_band || at_low) state_in = S_SLEW;
            else state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_done) state_in = S_PREP;
         end
         S_PREP: state_in = S_DIV;
         S_DIV: begin
            if (div_done) state_in = S_SLEW;
         end
         S_SLEW: state_in = S_CODE;
         S_CODE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      last_duty_in   = last_duty_ff;
      temp_in        = temp_ff;
      cnt_in         = cnt_ff;
      mul_sh_in      = mul_sh_ff;
      mcand_in       = mcand_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      dq_in          = dq_ff;
      target_in      = target_ff;
      full_in        = full_ff;
      next_in        = next_ff;
      changed_in     = changed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_duty_in    = rsp_duty_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_changed_in = rsp_changed_ff;
      unique case (state_ff)
         S_IDLE: begin
            temp_in = hot_temp;
         end
         S_EVAL: begin
            full_in   = go_full;
            target_in = at_low ? min_duty_ff : '0;
            if (off_band) target_in = '0;
            mul_sh_in = min_duty_ff;
            mcand_in  = PROD_W'(full_temp_ff - temp_ff);
            acc_in    = '0;
            cnt_in    = '0;
         end
         S_MUL: begin
            acc_in    = acc_ff + (mul_sh_ff[0] ? mcand_ff : '0);
            mul_sh_in = mul_sh_ff >> 1;
            mcand_in  = mcand_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
         end
         S_PREP: begin
            rem_in = REM_W'(dividend >> QUO_W);
            dq_in  = dividend[QUO_W-1:0];
            cnt_in = '0;
         end
         S_DIV: begin
            rem_in = fits ? REM_W'(trial - div2) : REM_W'(trial);
            dq_in  = quo;
            cnt_in = cnt_ff + 1'b1;
            target_in = (quo > QUO_W'(DUTY_FULL)) ? DUTY_FULL : quo[DUTY_W-1:0];
         end
         S_SLEW: begin
            next_in      = slew_next;
            changed_in   = (slew_next != last_duty_ff);
            last_duty_in = slew_next;
         end
         S_CODE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_duty_in    = next_ff;
               rsp_code_in    = CODE_W'(code_prod >> RECIP_SHIFT);
               rsp_changed_in = changed_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_duty_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_duty_ff <= last_duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff        <= temp_in;
      cnt_ff         <= cnt_in;
      mul_sh_ff      <= mul_sh_in;
      mcand_ff       <= mcand_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      dq_ff          <= dq_in;
      target_ff      <= target_in;
      full_ff        <= full_in;
      next_ff        <= next_in;
      changed_ff     <= changed_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff  <= TEMP_WIDTH'(RST_MIN_TEMP);
         full_temp_ff <= TEMP_WIDTH'(RST_FULL_TEMP);
         deadband_ff  <= RST_DEADBAND;
         min_duty_ff  <= RST_MIN_DUTY;
         slew_step_ff <= RST_SLEW_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_TEMP:  min_temp_ff  <= csr_wdata;
            CSR_FULL_TEMP: full_temp_ff <= csr_wdata;
            CSR_DEADBAND:  deadband_ff  <= csr_wdata[DBAND_W-1:0];
            CSR_MIN_DUTY:  min_duty_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_SLEW_STEP: slew_step_ff <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      last_duty_ff <= DUTY_FULL)
      else $error("kept duty above full scale");

   a_rsp_from_code: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_CODE)
      else $error("response raised outside the code step");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (REM_W+1)'(rem_ff) < div2)
      else $error("divider remainder not below divisor");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SLEW |=> changed_ff == (next_ff != $past(last_duty_ff)))
      else $error("change flag does not match duty update");
`endif

endmodule
